### rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Types, codes and helpers shared by the markup tag tokenizer modules.
// ----------------------------------------------------------------------------
package mtt_pkg;

    // longest token kept; further characters are dropped and flagged
    localparam int MAX_TOKEN_LENGTH = 255;
    localparam int CNT_W = $clog2(MAX_TOKEN_LENGTH + 1);

    localparam int LEN_FIELD_MAX = 255;

    // input item kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_EOS     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // result events
    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_DONE = 2'd1;
    localparam logic [1:0] EV_EOS  = 2'd2;

    // token types
    localparam logic [1:0] TY_START = 2'd0;
    localparam logic [1:0] TY_DATA  = 2'd1;
    localparam logic [1:0] TY_END   = 2'd2;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
    localparam logic signed [7:0] DEPTH_MIN = -8'sd128;

    typedef enum logic [6:0] {
        ST_START     = 7'b0000001,
        ST_OPEN      = 7'b0000010,
        ST_NAME      = 7'b0000100,
        ST_DATA      = 7'b0001000,
        ST_CLOSE     = 7'b0010000,
        ST_AFTER_END = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    typedef struct packed {
        state_t            parse_state;
        logic signed [7:0] depth;
        logic [CNT_W-1:0]  chars;
        logic              overflow;
    } tok_state_t;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [1:0]        token_type;
        logic [7:0]        token_char;
        logic [7:0]        token_length;
        logic              truncated;
        logic signed [7:0] nesting_depth;
    } tok_result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [7:0] len_field(input logic [CNT_W-1:0] n);
        if (32'(n) > 32'(LEN_FIELD_MAX))
            return 8'(LEN_FIELD_MAX);
        return 8'(n);
    endfunction

endpackage

### rtl/markup_tag_tokenizer_core.sv
// ----------------------------------------------------------------------------
// markup_tag_tokenizer_core
// Streams start tags, data fields and end tags out one character per item.
// ----------------------------------------------------------------------------
// channel  dir  tdata                        tuser
// s_*      in   text_byte[7:0]               kind[1:0]
// m_*      out  type,char,len,trunc,depth    event_res[1:0]
//
// One input item per cycle while s_tready is high; its result, if any,
// appears in the output register on the next cycle. The parser state updates at accept.
// s_tready is low only while a result is held and m_tready is low.
// Reset puts the parser at the start state with depth, length and flag zero.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] token_type, [9:2] token_char, [17:10] token_length,
    // [18] truncated, [26:19] nesting_depth, [31:27] zero
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] event_res
);

    mtt_pkg::tok_state_t  st_reg;
    mtt_pkg::tok_state_t  st_next;
    mtt_pkg::tok_result_t res;
    mtt_pkg::tok_result_t out_reg;
    logic                 res_valid;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 accept;

    mtt_step u_step (
        .cur       (st_reg),
        .kind      (s_tuser),
        .text_byte (s_tdata),
        .nxt       (st_next),
        .res_valid (res_valid),
        .res       (res)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (accept && res_valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.parse_state <= mtt_pkg::ST_START;
            st_reg.depth       <= '0;
            st_reg.chars       <= '0;
            st_reg.overflow    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
                st_reg <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {5'd0, out_reg.nesting_depth, out_reg.truncated,
                       out_reg.token_length, out_reg.token_char, out_reg.token_type};

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser == mtt_pkg::KIND_RESTART |=>
            st_reg.parse_state == mtt_pkg::ST_START && st_reg.depth == 8'sd0 &&
            st_reg.chars == '0 && !st_reg.overflow)
        else $error("restart did not clear parser state");

    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser == mtt_pkg::KIND_EOS |=>
            m_tvalid && m_tuser == mtt_pkg::EV_EOS && m_tdata[18:0] == 19'd0)
        else $error("end of stream result missing or not clean");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(st_reg.chars) <= 32'(mtt_pkg::MAX_TOKEN_LENGTH))
        else $error("token length beyond buffer size");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != mtt_pkg::EV_CHAR |-> m_tdata[9:2] == 8'd0)
        else $error("token_char not zero on completion item");
`endif

endmodule

### rtl/mtt_step.sv
// ----------------------------------------------------------------------------
// mtt_step
// Next-state and result logic for one input item of the tokenizer.
// ----------------------------------------------------------------------------
module mtt_step (
    input  mtt_pkg::tok_state_t  cur,
    input  logic [1:0]           kind,
    input  logic [7:0]           text_byte,
    output mtt_pkg::tok_state_t  nxt,
    output logic                 res_valid,
    output mtt_pkg::tok_result_t res
);

    logic       do_add;
    logic       do_fin;
    logic [1:0] ttype;

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        do_add    = 1'b0;
        do_fin    = 1'b0;
        ttype     = mtt_pkg::TY_START;

        if (kind == mtt_pkg::KIND_RESTART)
        begin
            nxt.parse_state = mtt_pkg::ST_START;
            nxt.depth       = '0;
            nxt.chars       = '0;
            nxt.overflow    = 1'b0;
        end
        else if (kind == mtt_pkg::KIND_EOS)
        begin
            nxt.parse_state   = mtt_pkg::ST_DONE;
            nxt.chars         = '0;
            nxt.overflow      = 1'b0;
            res_valid         = 1'b1;
            res.event_res     = mtt_pkg::EV_EOS;
            res.nesting_depth = cur.depth;
        end
        else if (kind == mtt_pkg::KIND_BYTE)
        begin
            unique case (cur.parse_state)
                mtt_pkg::ST_START, mtt_pkg::ST_AFTER_END:
                begin
                    if (text_byte == mtt_pkg::CH_LT)
                        nxt.parse_state = mtt_pkg::ST_OPEN;
                end
                mtt_pkg::ST_OPEN:
                begin
                    if (!mtt_pkg::is_blank(text_byte))
                    begin
                        if (text_byte == mtt_pkg::CH_SLASH)
                            nxt.parse_state = mtt_pkg::ST_CLOSE;
                        else if (text_byte == mtt_pkg::CH_GT)
                            nxt.parse_state = mtt_pkg::ST_DATA;
                        else
                        begin
                            nxt.parse_state = mtt_pkg::ST_NAME;
                            do_add          = 1'b1;
                        end
                    end
                end
                mtt_pkg::ST_NAME:
                begin
                    if (!mtt_pkg::is_blank(text_byte))
                    begin
                        if (text_byte == mtt_pkg::CH_GT)
                        begin
                            nxt.parse_state = mtt_pkg::ST_DATA;
                            if (cur.depth != mtt_pkg::DEPTH_MAX)
                                nxt.depth = cur.depth + 8'sd1;
                            do_fin = 1'b1;
                        end
                        else
                            do_add = 1'b1;
                    end
                end
                mtt_pkg::ST_DATA:
                begin
                    ttype = mtt_pkg::TY_DATA;
                    if (text_byte == mtt_pkg::CH_LT)
                    begin
                        nxt.parse_state = mtt_pkg::ST_OPEN;
                        do_fin          = 1'b1;
                    end
                    else
                        do_add = 1'b1;
                end
                mtt_pkg::ST_CLOSE:
                begin
                    ttype = mtt_pkg::TY_END;
                    if (!mtt_pkg::is_blank(text_byte))
                    begin
                        if (text_byte == mtt_pkg::CH_GT)
                        begin
                            nxt.parse_state = mtt_pkg::ST_AFTER_END;
                            if (cur.depth != mtt_pkg::DEPTH_MIN)
                                nxt.depth = cur.depth - 8'sd1;
                            do_fin = 1'b1;
                        end
                        else
                            do_add = 1'b1;
                    end
                end
                default:
                begin
                    // finished stream: bytes ignored until restart
                end
            endcase

            if (do_add)
            begin
                if (cur.chars >= mtt_pkg::CNT_W'(mtt_pkg::MAX_TOKEN_LENGTH))
                    nxt.overflow = 1'b1;
                else
                begin
                    nxt.chars         = cur.chars + 1'b1;
                    res_valid         = 1'b1;
                    res.event_res     = mtt_pkg::EV_CHAR;
                    res.token_type    = ttype;
                    res.token_char    = text_byte;
                    res.token_length  = mtt_pkg::len_field(nxt.chars);
                    res.truncated     = cur.overflow;
                    res.nesting_depth = nxt.depth;
                end
            end
            else if (do_fin)
            begin
                res_valid         = 1'b1;
                res.event_res     = mtt_pkg::EV_DONE;
                res.token_type    = ttype;
                res.token_length  = mtt_pkg::len_field(cur.chars);
                res.truncated     = cur.overflow;
                res.nesting_depth = nxt.depth;
                nxt.chars         = '0;
                nxt.overflow      = 1'b0;
            end
        end
    end

endmodule
